@@ rtl/core/isq_pkg.sv @@
// Shared types, constants and the control program of the indexed sequential search block.
package isq_pkg;

  localparam int unsigned DEF_PAGE_SIZE = 16;
  localparam int unsigned DEF_CAPACITY  = 1024;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 10;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    STEP_DONE,
    STEP_IDLE,
    STEP_LOAD,
    STEP_CLEAR,
    STEP_SCAN_RD,
    STEP_SCAN_CMP,
    STEP_PAGE,
    STEP_RD_LO,
    STEP_RD_HI,
    STEP_RD_MID,
    STEP_RANGE,
    STEP_HIT,
    STEP_BS_STEP,
    STEP_MISS
  } step_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_EMIT,
    DP_ACCEPT,
    DP_LOAD,
    DP_CLEAR,
    DP_IDX_RD,
    DP_SCAN_STEP,
    DP_PAGE,
    DP_RD_LO,
    DP_RD_HI,
    DP_RD_MID,
    DP_HIT,
    DP_BS_STEP,
    DP_MISS
  } dp_op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_OUT_BUSY,
    C_SCAN_END,
    C_NOT_PAST,
    C_NO_PAGE,
    C_LO_GT_HI,
    C_OUT_RANGE,
    C_HIT
  } cond_e;

  typedef struct packed {
    dp_op_e dp;
    cond_e  cond;
    step_e  target;
  } ctrl_word_t;

  typedef struct packed {
    logic            accept;
    logic [OP_W-1:0] op;
    logic            out_busy;
    logic            scan_end;
    logic            not_past;
    logic            no_page;
    logic            lo_gt_hi;
    logic            out_range;
    logic            hit;
  } seq_flags_t;

  // Control store: a conditional step jumps to target when its condition holds, and falls
  // through to the following step otherwise; the dispatch step holds until a request is taken.
  function automatic ctrl_word_t ucode_rom(step_e s);
    ctrl_word_t w;
    case (s)
      STEP_DONE:     w = '{dp: DP_EMIT,      cond: C_OUT_BUSY,  target: STEP_DONE};
      STEP_IDLE:     w = '{dp: DP_ACCEPT,    cond: C_DISPATCH,  target: STEP_IDLE};
      STEP_LOAD:     w = '{dp: DP_LOAD,      cond: C_ALWAYS,    target: STEP_DONE};
      STEP_CLEAR:    w = '{dp: DP_CLEAR,     cond: C_ALWAYS,    target: STEP_DONE};
      STEP_SCAN_RD:  w = '{dp: DP_IDX_RD,    cond: C_SCAN_END,  target: STEP_PAGE};
      STEP_SCAN_CMP: w = '{dp: DP_SCAN_STEP, cond: C_NOT_PAST,  target: STEP_SCAN_RD};
      STEP_PAGE:     w = '{dp: DP_PAGE,      cond: C_NO_PAGE,   target: STEP_MISS};
      STEP_RD_LO:    w = '{dp: DP_RD_LO,     cond: C_LO_GT_HI,  target: STEP_MISS};
      STEP_RD_HI:    w = '{dp: DP_RD_HI,     cond: C_NEXT,      target: STEP_IDLE};
      STEP_RD_MID:   w = '{dp: DP_RD_MID,    cond: C_NEXT,      target: STEP_IDLE};
      STEP_RANGE:    w = '{dp: DP_NONE,      cond: C_OUT_RANGE, target: STEP_MISS};
      STEP_HIT:      w = '{dp: DP_HIT,       cond: C_HIT,       target: STEP_DONE};
      STEP_BS_STEP:  w = '{dp: DP_BS_STEP,   cond: C_ALWAYS,    target: STEP_RD_LO};
      STEP_MISS:     w = '{dp: DP_MISS,      cond: C_ALWAYS,    target: STEP_DONE};
      default:       w = '{dp: DP_NONE,      cond: C_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_e dispatch_step(logic [OP_W-1:0] op);
    step_e s;
    case (op)
      OP_LOAD:   s = STEP_LOAD;
      OP_SEARCH: s = STEP_SCAN_RD;
      OP_CLEAR:  s = STEP_CLEAR;
      default:   s = STEP_DONE;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/isq_if.sv @@
// Request, response and configuration channel interfaces.
interface isq_req_if import isq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [KEY_W-1:0]  key;
  logic [DATA_W-1:0]        record_data;

  modport source (output valid, op, key, record_data, input ready);
  modport sink   (input valid, op, key, record_data, output ready);
endinterface

interface isq_rsp_if import isq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [POS_W-1:0]         position;
  logic [DATA_W-1:0]        found_data;
  logic signed [KEY_W-1:0]  found_key;

  modport source (output valid, status, position, found_data, found_key, input ready);
  modport sink   (input valid, status, position, found_data, found_key, output ready);
endinterface

interface isq_cfg_if ();
  logic valid;
  logic ready;
  logic sort_order;

  modport source (output valid, sort_order, input ready);
  modport sink   (input valid, sort_order, output ready);
endinterface

@@ rtl/core/indexed_sequential_search.sv @@
// A load or clear request passes through its load or clear step to the result step; op code 3
// goes straight to the result step. A search passes at most ceil(CAPACITY / PAGE_SIZE) index
// pages and makes at most log2(PAGE_SIZE) + 1 binary-search probes, reading through one read
// port each on the index memory and the record memory.
// A new request is taken the cycle after the result enters the output register.
// Reset empties the store and sets ascending order; memory contents are not cleared.
module indexed_sequential_search import isq_pkg::*; #(
  parameter int unsigned PAGE_SIZE = DEF_PAGE_SIZE,
  parameter int unsigned CAPACITY  = DEF_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  isq_req_if.sink     req_i,
  isq_rsp_if.source   rsp_o,
  isq_cfg_if.sink     cfg_i
);

  localparam int unsigned MAX_PAGES = (CAPACITY + PAGE_SIZE - 1) / PAGE_SIZE;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned PG_AW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned PGC_W     = $clog2(MAX_PAGES + 1);
  localparam int unsigned OFF_W     = $clog2(PAGE_SIZE);
  localparam int unsigned NW        = OFF_W + 1;
  localparam int unsigned LH_W      = OFF_W + 2;
  localparam int unsigned SB_W      = $clog2(MAX_PAGES * PAGE_SIZE + 1);
  localparam int unsigned REC_W     = KEY_W + DATA_W;

  function automatic logic [ADDR_W-1:0] rec_addr(logic [ADDR_W-1:0] b, logic [OFF_W-1:0] o);
    logic [ADDR_W+OFF_W-1:0] s;
    s = (ADDR_W + OFF_W)'(b) + (ADDR_W + OFF_W)'(o);
    return s[ADDR_W-1:0];
  endfunction

  ctrl_word_t ctrl;
  seq_flags_t flags;

  // Control registers
  logic [CNT_W-1:0] rc_q, rc_d;
  logic [PGC_W-1:0] pgc_q, pgc_d;
  logic [OFF_W-1:0] fill_q, fill_d;
  logic             sort_q, sort_d;
  logic             out_valid_q, out_valid_d;

  // Datapath registers
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [DATA_W-1:0]       data_q, data_d;
  logic [PGC_W-1:0]        i_q, i_d;
  logic [SB_W-1:0]         scan_base_q, scan_base_d;
  logic [ADDR_W-1:0]       base_q, base_d;
  logic signed [LH_W-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [KEY_W-1:0] klo_q, klo_d, khi_q, khi_d;
  status_e                 res_status_q, res_status_d;
  logic [POS_W-1:0]        res_pos_q, res_pos_d;
  logic [DATA_W-1:0]       res_data_q, res_data_d;
  logic signed [KEY_W-1:0] res_key_q, res_key_d;
  status_e                 out_status_q, out_status_d;
  logic [POS_W-1:0]        out_pos_q, out_pos_d;
  logic [DATA_W-1:0]       out_data_q, out_data_d;
  logic signed [KEY_W-1:0] out_key_q, out_key_d;

  // Memory ports
  logic              rec_we, rec_re, idx_we, idx_re;
  logic [ADDR_W-1:0] rec_waddr, rec_raddr;
  logic [PG_AW-1:0]  idx_waddr, idx_raddr;
  logic [REC_W-1:0]  rec_rdata;
  logic [KEY_W-1:0]  idx_rdata;

  // Combinational helpers
  logic                    accept, full, out_busy, emit;
  logic [SB_W-1:0]         rc_ext, base_c, diff_c;
  logic [NW-1:0]           n_c;
  logic signed [LH_W-1:0]  mid_c;
  logic signed [KEY_W-1:0] rec_key, idx_key;
  logic                    not_past_c, out_range_c, hit_c;
  logic [ADDR_W+POS_W-1:0] pos_ext;

  assign req_i.ready = (ctrl.dp == DP_ACCEPT);
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign full        = (rc_q == CNT_W'(CAPACITY));
  assign out_busy    = out_valid_q && !rsp_o.ready;
  assign emit        = (ctrl.dp == DP_EMIT) && !out_busy;

  assign rec_key = $signed(rec_rdata[REC_W-1:DATA_W]);
  assign idx_key = $signed(idx_rdata);

  // Length of the page just before the scan stopped, clipped to the fill level.
  assign rc_ext = SB_W'(rc_q);
  assign base_c = scan_base_q - SB_W'(PAGE_SIZE);
  assign diff_c = rc_ext - base_c;
  always_comb begin
    if (base_c < rc_ext) begin
      n_c = (diff_c > SB_W'(PAGE_SIZE)) ? NW'(PAGE_SIZE) : NW'(diff_c);
    end else begin
      n_c = '0;
    end
  end

  assign mid_c = (lo_q + hi_q) >>> 1;

  assign not_past_c  = sort_q ? (idx_key >= key_q) : (idx_key <= key_q);
  assign out_range_c = sort_q ? ((key_q < khi_q) || (key_q > klo_q))
                              : ((key_q > khi_q) || (key_q < klo_q));
  assign hit_c       = (key_q == rec_key);
  assign pos_ext     = (ADDR_W + POS_W)'(rec_addr(base_q, mid_q[OFF_W-1:0]));

  always_comb begin
    flags.accept    = accept;
    flags.op        = req_i.op;
    flags.out_busy  = out_busy;
    flags.scan_end  = (i_q >= pgc_q);
    flags.not_past  = not_past_c;
    flags.no_page   = (i_q == '0) || (n_c == '0);
    flags.lo_gt_hi  = (lo_q > hi_q);
    flags.out_range = out_range_c;
    flags.hit       = hit_c;
  end

  isq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // Memory control
  assign rec_we    = (ctrl.dp == DP_LOAD) && !full;
  assign rec_waddr = rc_q[ADDR_W-1:0];
  assign idx_we    = rec_we && (fill_q == '0) && (pgc_q < PGC_W'(MAX_PAGES));
  assign idx_waddr = pgc_q[PG_AW-1:0];
  assign idx_re    = (ctrl.dp == DP_IDX_RD);
  assign idx_raddr = i_q[PG_AW-1:0];
  assign rec_re    = (ctrl.dp == DP_RD_LO) || (ctrl.dp == DP_RD_HI) || (ctrl.dp == DP_RD_MID);

  always_comb begin
    case (ctrl.dp)
      DP_RD_HI:  rec_raddr = rec_addr(base_q, hi_q[OFF_W-1:0]);
      DP_RD_MID: rec_raddr = rec_addr(base_q, mid_c[OFF_W-1:0]);
      default:   rec_raddr = rec_addr(base_q, lo_q[OFF_W-1:0]);
    endcase
  end

  isq_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY),
    .AW    (ADDR_W)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i ({key_q, data_q}),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  isq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_PAGES),
    .AW    (PG_AW)
  ) u_idx_ram (
    .clk_i   (clk_i),
    .we_i    (idx_we),
    .waddr_i (idx_waddr),
    .wdata_i (key_q),
    .re_i    (idx_re),
    .raddr_i (idx_raddr),
    .rdata_o (idx_rdata)
  );

  // Datapath controlled by the current control word
  always_comb begin
    rc_d         = rc_q;
    pgc_d        = pgc_q;
    fill_d       = fill_q;
    sort_d       = cfg_i.valid ? cfg_i.sort_order : sort_q;
    key_d        = key_q;
    data_d       = data_q;
    i_d          = i_q;
    scan_base_d  = scan_base_q;
    base_d       = base_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    klo_d        = klo_q;
    khi_d        = khi_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_data_d   = res_data_q;
    res_key_d    = res_key_q;

    case (ctrl.dp)
      DP_ACCEPT: begin
        if (accept) begin
          key_d        = req_i.key;
          data_d       = req_i.record_data;
          i_d          = '0;
          scan_base_d  = '0;
          res_status_d = ST_OK;
          res_pos_d    = '0;
          res_data_d   = '0;
          res_key_d    = '0;
        end
      end
      DP_LOAD: begin
        if (full) begin
          res_status_d = ST_FULL;
        end else begin
          rc_d   = rc_q + CNT_W'(1);
          fill_d = (fill_q == OFF_W'(PAGE_SIZE - 1)) ? '0 : fill_q + OFF_W'(1);
          if (idx_we) begin
            pgc_d = pgc_q + PGC_W'(1);
          end
        end
      end
      DP_CLEAR: begin
        rc_d   = '0;
        pgc_d  = '0;
        fill_d = '0;
      end
      DP_SCAN_STEP: begin
        if (not_past_c) begin
          i_d         = i_q + PGC_W'(1);
          scan_base_d = scan_base_q + SB_W'(PAGE_SIZE);
        end
      end
      DP_PAGE: begin
        base_d = base_c[ADDR_W-1:0];
        lo_d   = '0;
        hi_d   = LH_W'(n_c) - LH_W'(1);
      end
      DP_RD_HI: begin
        klo_d = rec_key;
      end
      DP_RD_MID: begin
        khi_d = rec_key;
        mid_d = mid_c;
      end
      DP_HIT: begin
        if (hit_c) begin
          res_status_d = ST_OK;
          res_pos_d    = pos_ext[POS_W-1:0];
          res_data_d   = rec_rdata[DATA_W-1:0];
          res_key_d    = rec_key;
        end
      end
      DP_BS_STEP: begin
        // Ascending order moves up on a larger key, descending order moves down.
        if ((key_q > rec_key) != sort_q) begin
          lo_d = mid_q + LH_W'(1);
        end else begin
          hi_d = mid_q - LH_W'(1);
        end
      end
      DP_MISS: begin
        res_status_d = ST_NOT_FOUND;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d  = rsp_o.ready ? 1'b0 : out_valid_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_data_d   = out_data_q;
    out_key_d    = out_key_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_pos_d    = res_pos_q;
      out_data_d   = res_data_q;
      out_key_d    = res_key_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.position   = out_pos_q;
  assign rsp_o.found_data = out_data_q;
  assign rsp_o.found_key  = out_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q        <= '0;
      pgc_q       <= '0;
      fill_q      <= '0;
      sort_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rc_q        <= rc_d;
      pgc_q       <= pgc_d;
      fill_q      <= fill_d;
      sort_q      <= sort_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    data_q       <= data_d;
    i_q          <= i_d;
    scan_base_q  <= scan_base_d;
    base_q       <= base_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    klo_q        <= klo_d;
    khi_q        <= khi_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_data_q   <= res_data_d;
    res_key_q    <= res_key_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_data_q   <= out_data_d;
    out_key_q    <= out_key_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc_q <= CNT_W'(CAPACITY)) && (pgc_q <= PGC_W'(MAX_PAGES)))
    else $error("record or page count beyond capacity");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (ctrl.dp != DP_ACCEPT))
    else $error("request accepted but sequencer stayed idle");

  a_probe_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.dp == DP_RD_HI) |-> (!lo_q[LH_W-1] && (hi_q < $signed(LH_W'(PAGE_SIZE)))))
    else $error("binary search bounds left the page");

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.dp == DP_EMIT && out_valid_q && !rsp_o.ready) |=> (ctrl.dp == DP_EMIT))
    else $error("result step left while output register was occupied");
`endif

endmodule

@@ rtl/core/isq_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module isq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/isq_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
module isq_seq import isq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_flags_t flags_i,
  output ctrl_word_t ctrl_o
);

  step_e      step_q, step_d;
  ctrl_word_t ctrl;
  logic       cond_true;

  assign ctrl   = ucode_rom(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    cond_true = 1'b0;
    case (ctrl.cond)
      C_OUT_BUSY:  cond_true = flags_i.out_busy;
      C_SCAN_END:  cond_true = flags_i.scan_end;
      C_NOT_PAST:  cond_true = flags_i.not_past;
      C_NO_PAGE:   cond_true = flags_i.no_page;
      C_LO_GT_HI:  cond_true = flags_i.lo_gt_hi;
      C_OUT_RANGE: cond_true = flags_i.out_range;
      C_HIT:       cond_true = flags_i.hit;
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     step_d = step_e'(step_q + 4'd1);
      C_ALWAYS:   step_d = ctrl.target;
      C_DISPATCH: step_d = flags_i.accept ? dispatch_step(flags_i.op) : step_q;
      default:    step_d = cond_true ? ctrl.target : step_e'(step_q + 4'd1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
